// ===== hw/rtl/vector_to_angle_degrees_macros.svh =====
// Assertion macros for the vector_to_angle_degrees block.
`ifndef VECTOR_TO_ANGLE_DEGREES_MACROS_SVH
`define VECTOR_TO_ANGLE_DEGREES_MACROS_SVH

`ifndef ASSERT_OFF

// Condition holds at every clock edge outside reset.
`define VTAD_ASSERT_ALWAYS(label, clk_s, rst_s, cond) \
  label: assert property (@(posedge clk_s) disable iff (!(rst_s)) (cond)) \
    else $error("assertion failed");

// Trigger is followed by the consequence a fixed number of cycles later.
`define VTAD_ASSERT_DELAY(label, clk_s, rst_s, trig, n, cons) \
  label: assert property (@(posedge clk_s) disable iff (!(rst_s)) \
    (trig) |-> ##(n) (cons)) else $error("assertion failed");

`else

`define VTAD_ASSERT_ALWAYS(label, clk_s, rst_s, cond)
`define VTAD_ASSERT_DELAY(label, clk_s, rst_s, trig, n, cons)

`endif

`endif

// ===== hw/rtl/vtad_pkg.sv =====
// Shared constants, types and the arctangent table of the vector angle block.
package vtad_pkg;

  localparam int COORD_WIDTH     = 16;
  localparam int ANGLE_FRAC_BITS = 7;
  localparam int OUT_W           = ANGLE_FRAC_BITS + 10;
  localparam int TAB_FRAC        = 20;
  localparam int ITER            = 24;
  localparam int IDX_W           = $clog2(ITER);
  localparam int GUARD_SHIFT     = 60 - COORD_WIDTH;
  localparam int DW              = 64;
  localparam int ZW              = 28;
  localparam int FW              = ZW + 2;
  localparam int RND_SH          = TAB_FRAC - ANGLE_FRAC_BITS;
  // input register, one register per cell, output register
  localparam int LATENCY         = ITER + 2;

  typedef struct packed {
    logic valid;
    logic x_neg;
    logic x_zero;
    logic y_pos;
  } ctrl_t;

  // atan(2^-i) in units of 2^-20 degree
  function automatic logic signed [ZW-1:0] atan_tab(input logic [IDX_W-1:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      5'd0:    v = ZW'(47185920);
      5'd1:    v = ZW'(27855475);
      5'd2:    v = ZW'(14718068);
      5'd3:    v = ZW'(7471121);
      5'd4:    v = ZW'(3750058);
      5'd5:    v = ZW'(1876857);
      5'd6:    v = ZW'(938658);
      5'd7:    v = ZW'(469357);
      5'd8:    v = ZW'(234682);
      5'd9:    v = ZW'(117342);
      5'd10:   v = ZW'(58671);
      5'd11:   v = ZW'(29335);
      5'd12:   v = ZW'(14668);
      5'd13:   v = ZW'(7334);
      5'd14:   v = ZW'(3667);
      5'd15:   v = ZW'(1833);
      5'd16:   v = ZW'(917);
      5'd17:   v = ZW'(458);
      5'd18:   v = ZW'(229);
      5'd19:   v = ZW'(115);
      5'd20:   v = ZW'(57);
      5'd21:   v = ZW'(29);
      5'd22:   v = ZW'(14);
      5'd23:   v = ZW'(7);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/vtad_cell.sv =====
// One CORDIC vectoring micro-rotation cell with its pipeline register.
module vtad_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [vtad_pkg::IDX_W-1:0]    idx,
  input  vtad_pkg::ctrl_t               ctrl_in,
  input  logic signed [vtad_pkg::DW-1:0] x_in,
  input  logic signed [vtad_pkg::DW-1:0] y_in,
  input  logic signed [vtad_pkg::ZW-1:0] z_in,
  output vtad_pkg::ctrl_t               ctrl_out,
  output logic signed [vtad_pkg::DW-1:0] x_out,
  output logic signed [vtad_pkg::DW-1:0] y_out,
  output logic signed [vtad_pkg::ZW-1:0] z_out
);

  vtad_pkg::ctrl_t                ctrl_r;
  logic signed [vtad_pkg::DW-1:0] x_r, x_nxt;
  logic signed [vtad_pkg::DW-1:0] y_r, y_nxt;
  logic signed [vtad_pkg::ZW-1:0] z_r, z_nxt;
  logic signed [vtad_pkg::DW-1:0] dx, dy;
  logic signed [vtad_pkg::ZW-1:0] ang;

  // arithmetic shift rounds toward minus infinity
  assign dx  = y_in >>> idx;
  assign dy  = x_in >>> idx;
  assign ang = vtad_pkg::atan_tab(idx);

  always_comb begin
    if (y_in[vtad_pkg::DW-1]) begin
      x_nxt = x_in - dx;
      y_nxt = y_in + dy;
      z_nxt = z_in - ang;
    end else begin
      x_nxt = x_in + dx;
      y_nxt = y_in - dy;
      z_nxt = z_in + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else begin
      ctrl_r <= ctrl_in;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign ctrl_out = ctrl_r;
  assign x_out    = x_r;
  assign y_out    = y_r;
  assign z_out    = z_r;

endmodule

// ===== hw/rtl/vtad_final.sv =====
// Output stage: clamp, quadrant fix-up, rounding and the zero-x special case.
module vtad_final (
  input  logic                           clk,
  input  logic                           rst_n,
  input  vtad_pkg::ctrl_t                ctrl_in,
  input  logic signed [vtad_pkg::ZW-1:0] z_in,
  output logic                           valid_out,
  output logic signed [vtad_pkg::OUT_W-1:0] angle_out
);

  localparam logic signed [vtad_pkg::ZW-1:0] Z_LIM =
    vtad_pkg::ZW'(90 * (2 ** vtad_pkg::TAB_FRAC));
  localparam logic signed [vtad_pkg::FW-1:0] HALF_TURN =
    vtad_pkg::FW'(180 * (2 ** vtad_pkg::TAB_FRAC));
  localparam logic signed [vtad_pkg::FW-1:0] RND_HALF =
    vtad_pkg::FW'(2 ** (vtad_pkg::RND_SH - 1));
  localparam logic signed [vtad_pkg::FW-1:0] R_MIN =
    -vtad_pkg::FW'(90 * (2 ** vtad_pkg::ANGLE_FRAC_BITS));
  localparam logic signed [vtad_pkg::FW-1:0] R_90 =
    vtad_pkg::FW'(90 * (2 ** vtad_pkg::ANGLE_FRAC_BITS));
  localparam logic signed [vtad_pkg::FW-1:0] R_MAX =
    vtad_pkg::FW'(270 * (2 ** vtad_pkg::ANGLE_FRAC_BITS));

  logic signed [vtad_pkg::ZW-1:0]    z_cl;
  logic signed [vtad_pkg::FW-1:0]    z_ext, full, rnd, r, res;
  logic                              valid_r;
  logic signed [vtad_pkg::OUT_W-1:0] angle_r, angle_nxt;

  always_comb begin
    if (z_in > Z_LIM) begin
      z_cl = Z_LIM;
    end else if (z_in < -Z_LIM) begin
      z_cl = -Z_LIM;
    end else begin
      z_cl = z_in;
    end
    z_ext = {{(vtad_pkg::FW - vtad_pkg::ZW){z_cl[vtad_pkg::ZW-1]}}, z_cl};
    full  = ctrl_in.x_neg ? (HALF_TURN - z_ext) : z_ext;
    // round half up to the output precision
    rnd   = (full + RND_HALF) >>> vtad_pkg::RND_SH;
    if (rnd < R_MIN) begin
      r = R_MIN;
    end else if (rnd > R_MAX) begin
      r = R_MAX;
    end else begin
      r = rnd;
    end
    if (ctrl_in.x_zero) begin
      res = ctrl_in.y_pos ? R_90 : R_MAX;
    end else begin
      res = r;
    end
    angle_nxt = res[vtad_pkg::OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctrl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    angle_r <= angle_nxt;
  end

  assign valid_out = valid_r;
  assign angle_out = angle_r;

endmodule

// ===== hw/rtl/vector_to_angle_degrees.sv =====
// Top level of the vector direction block: input register, CORDIC cell chain, output stage.
//
// Usage:
//   Drive in_x_component and in_y_component (signed 16-bit) and raise start;
//   the item is taken at every clock edge where start is high and busy is
//   low. busy stays low, so a new vector may enter on every clock cycle.
//   The direction comes out on out_angle_degrees as signed degrees times
//   128 (-90 to 270), marked by a one-cycle out_valid strobe.
//   An item passes from the accepting edge through one input register,
//   24 CORDIC cells (one micro-rotation each, a 64-bit add/subtract pair
//   per cell) and one output register before its result is taken.
//   Throughput is one item per cycle; items leave in the order they came.
//   The receiver cannot hold results off: out_valid and the angle are
//   shown for exactly one cycle.
//   A synchronous reset (rst_n low) drops every item in flight; no result
//   from before the reset appears afterwards.
`include "vector_to_angle_degrees_macros.svh"

module vector_to_angle_degrees (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [vtad_pkg::COORD_WIDTH-1:0] in_x_component,
  input  logic signed [vtad_pkg::COORD_WIDTH-1:0] in_y_component,
  output logic                                  out_valid,
  output logic signed [vtad_pkg::OUT_W-1:0]     out_angle_degrees
);

  localparam int EXT_W = vtad_pkg::DW - vtad_pkg::COORD_WIDTH;
  localparam logic signed [vtad_pkg::OUT_W-1:0] ANGLE_LO =
    -vtad_pkg::OUT_W'(90 * (2 ** vtad_pkg::ANGLE_FRAC_BITS));
  localparam logic signed [vtad_pkg::OUT_W-1:0] ANGLE_HI =
    vtad_pkg::OUT_W'(270 * (2 ** vtad_pkg::ANGLE_FRAC_BITS));

  logic                           accept;
  logic                           angle_ok;
  logic signed [vtad_pkg::DW-1:0] x_ext, y_ext, x_abs;
  vtad_pkg::ctrl_t                ctrl_r, ctrl_nxt;
  logic signed [vtad_pkg::DW-1:0] x_r, x_nxt;
  logic signed [vtad_pkg::DW-1:0] y_r, y_nxt;

  vtad_pkg::ctrl_t                ctrl_s [0:vtad_pkg::ITER];
  logic signed [vtad_pkg::DW-1:0] x_s    [0:vtad_pkg::ITER];
  logic signed [vtad_pkg::DW-1:0] y_s    [0:vtad_pkg::ITER];
  logic signed [vtad_pkg::ZW-1:0] z_s    [0:vtad_pkg::ITER];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    x_ext           = {{EXT_W{in_x_component[vtad_pkg::COORD_WIDTH-1]}}, in_x_component};
    y_ext           = {{EXT_W{in_y_component[vtad_pkg::COORD_WIDTH-1]}}, in_y_component};
    x_abs           = in_x_component[vtad_pkg::COORD_WIDTH-1] ? -x_ext : x_ext;
    x_nxt           = x_abs <<< vtad_pkg::GUARD_SHIFT;
    y_nxt           = y_ext <<< vtad_pkg::GUARD_SHIFT;
    ctrl_nxt.valid  = accept;
    ctrl_nxt.x_neg  = in_x_component[vtad_pkg::COORD_WIDTH-1];
    ctrl_nxt.x_zero = (in_x_component == '0);
    ctrl_nxt.y_pos  = !in_y_component[vtad_pkg::COORD_WIDTH-1] && (in_y_component != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else begin
      ctrl_r <= ctrl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
  end

  assign ctrl_s[0] = ctrl_r;
  assign x_s[0]    = x_r;
  assign y_s[0]    = y_r;
  assign z_s[0]    = '0;

  for (genvar k = 0; k < vtad_pkg::ITER; k++) begin : g_cell
    vtad_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .idx      (vtad_pkg::IDX_W'(k)),
      .ctrl_in  (ctrl_s[k]),
      .x_in     (x_s[k]),
      .y_in     (y_s[k]),
      .z_in     (z_s[k]),
      .ctrl_out (ctrl_s[k+1]),
      .x_out    (x_s[k+1]),
      .y_out    (y_s[k+1]),
      .z_out    (z_s[k+1])
    );
  end

  vtad_final u_final (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl_in   (ctrl_s[vtad_pkg::ITER]),
    .z_in      (z_s[vtad_pkg::ITER]),
    .valid_out (out_valid),
    .angle_out (out_angle_degrees)
  );

  assign angle_ok = (out_angle_degrees >= ANGLE_LO) && (out_angle_degrees <= ANGLE_HI);

  // every accepted item yields its result after the fixed latency
  `VTAD_ASSERT_DELAY(a_latency, clk, rst_n, accept, vtad_pkg::LATENCY, out_valid)
  // a result is only ever produced for an item taken the fixed latency earlier
  `VTAD_ASSERT_DELAY(a_no_spurious, clk, rst_n, !accept, vtad_pkg::LATENCY, !out_valid)
  // results stay within -90 to 270 degrees
  `VTAD_ASSERT_ALWAYS(a_range, clk, rst_n, !out_valid || angle_ok)

endmodule
